// ===== rtl/sde_pkg.sv =====
// shared types, codes and helpers for the sparse dag network evaluator
`timescale 1ns / 1ps
package sde_pkg;

  // operation codes of an input word
  localparam logic [1:0] OP_NEURON = 2'd0;
  localparam logic [1:0] OP_EDGE   = 2'd1;
  localparam logic [1:0] OP_PREP   = 2'd2;
  localparam logic [1:0] OP_INPUT  = 2'd3;

  // status codes of a result word
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_CYCLE   = 2'd2;
  localparam logic [1:0] ST_NOPREP  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
  localparam logic [1:0] REG_OUTPUT_COUNT = 2'd1;

  localparam int CountMax = 32;

  typedef struct packed {
    logic [1:0]         op;
    logic [5:0]         neuron_slot;
    logic [7:0]         edge_slot;
    logic               present;
    logic [5:0]         source_neuron;
    logic [5:0]         target_neuron;
    logic signed [15:0] value;
    logic               edge_enabled;
    logic               input_last;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [23:0] out_value;
    logic [4:0]         out_position;
    logic               last;
  } out_word_t;

  // neuron table entry
  typedef struct packed {
    logic               exists;
    logic signed [15:0] bias;
  } neuron_t;

  // connection table entry
  typedef struct packed {
    logic               valid;
    logic               enabled;
    logic [5:0]         source;
    logic [5:0]         target;
    logic signed [15:0] weight;
  } edge_t;

  // multiply-accumulate control
  typedef struct packed {
    logic load;
    logic add;
  } mac_ctrl_t;

  // clamp a register write into 1..32
  function automatic logic [5:0] clamp_count(logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (v == 6'd0) r = 6'd1;
    else if (v > 6'(CountMax)) r = 6'(CountMax);
    return r;
  endfunction

endpackage

// ===== rtl/sde_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read port
`timescale 1ns / 1ps
module sde_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                   wdata_i,
  input  logic                           re_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                   rdata_o
);

  logic [W-1:0] mem [D];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/sde_mac.sv =====
// weight times value accumulator with round, saturate and relu
`timescale 1ns / 1ps
module sde_mac #(
  parameter int ACC_W = 50
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sde_pkg::mac_ctrl_t ctrl_i,
  input  logic signed [15:0] bias_i,
  input  logic signed [15:0] weight_i,
  input  logic signed [23:0] value_i,
  output logic signed [23:0] result_o
);
  import sde_pkg::*;

  logic signed [39:0]      prod_q;
  logic                    add_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] shr;

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_q <= 1'b0;
    end else begin
      add_q <= ctrl_i.add;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.add) begin
      prod_q <= weight_i * value_i;
    end
  end

  // accumulate stage, bias enters scaled by 4096
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_q <= ACC_W'(bias_i) <<< 12;
    end else if (add_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // round half up, saturate, clamp at zero
  assign rnd = acc_q + ACC_W'(2048);
  assign shr = rnd >>> 12;

  always_comb begin
    if (shr[ACC_W-1]) begin
      result_o = '0;
    end else if (|shr[ACC_W-2:23]) begin
      result_o = 24'sh7FFFFF;
    end else begin
      result_o = shr[23:0];
    end
  end

endmodule

// ===== rtl/sparse_dag_network_evaluator.sv =====
// top level: command sequencer around the neuron, edge, order and value memories
//
// Usage: an input word is taken when start is high and busy is low. Neuron and
// connection writes and input values without input_last complete without leaving
// idle. Config writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at once,
// while idle. A prepare word runs a topological sort sequenced over the memories
// and returns one status word: it checks that the input and output slots exist,
// checks the endpoints of every active edge and counts in-degrees, then seeds the
// queue with zero-degree neurons and, for each neuron popped, visits every edge
// slot and updates the degree of each successor, queueing those released. An
// input word with input_last evaluates every non-input neuron in order, each one
// scanning all edge slots through the single edge memory port, then emits
// output_count words one after another. If the order is stale a single
// not-prepared status word follows at once.
// Results are shown for one cycle on result_o with result_valid_o; the receiver
// cannot stall. After reset a clearing pass over max(MAX_NEURONS, MAX_EDGES) entries
// wipes the neuron and connection tables; busy stays high during it.
module sparse_dag_network_evaluator #(
  parameter int MAX_NEURONS = 64,
  parameter int MAX_EDGES   = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sde_pkg::in_word_t in_word_i,
  output logic              result_valid_o,
  output sde_pkg::out_word_t result_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [5:0]        cfg_data_i
);
  import sde_pkg::*;

  localparam int NW    = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int EW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int NW1   = $clog2(MAX_NEURONS + 1);
  localparam int EW1   = $clog2(MAX_EDGES + 1);
  localparam int DW    = $clog2(MAX_EDGES + 1);
  localparam int MAXD  = (MAX_NEURONS > MAX_EDGES) ? MAX_NEURONS : MAX_EDGES;
  localparam int CW    = $clog2(MAXD + 1);
  localparam int ACC_W = 41 + $clog2(MAX_EDGES + 1);

  // sequencer states
  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] P_A_RD    = 5'd2;
  localparam logic [4:0] P_A_CHK   = 5'd3;
  localparam logic [4:0] P_B_RD    = 5'd4;
  localparam logic [4:0] P_B_E     = 5'd5;
  localparam logic [4:0] P_B_F     = 5'd6;
  localparam logic [4:0] P_B_T     = 5'd7;
  localparam logic [4:0] P_B_INC   = 5'd8;
  localparam logic [4:0] P_C_RD    = 5'd9;
  localparam logic [4:0] P_C_CHK   = 5'd10;
  localparam logic [4:0] P_D_POP   = 5'd11;
  localparam logic [4:0] P_D_CUR   = 5'd12;
  localparam logic [4:0] P_D_RD    = 5'd13;
  localparam logic [4:0] P_D_E     = 5'd14;
  localparam logic [4:0] P_D_DEC   = 5'd15;
  localparam logic [4:0] E_POP     = 5'd16;
  localparam logic [4:0] E_N       = 5'd17;
  localparam logic [4:0] E_B       = 5'd18;
  localparam logic [4:0] E_RD      = 5'd19;
  localparam logic [4:0] E_E       = 5'd20;
  localparam logic [4:0] E_V       = 5'd21;
  localparam logic [4:0] E_DR      = 5'd22;
  localparam logic [4:0] E_WB      = 5'd23;
  localparam logic [4:0] O_RD      = 5'd24;
  localparam logic [4:0] O_EM      = 5'd25;

  logic [4:0]     state_q, state_d;
  logic           ov_q, ov_d;
  logic [5:0]     ic_q, ic_d, oc_q, oc_d;
  logic [NW1-1:0] i_q, i_d, head_q, head_d, tail_q, tail_d, pc_q, pc_d, len_q, len_d;
  logic [EW1-1:0] e_q, e_d;
  logic [5:0]     j_q, j_d;
  logic [NW-1:0]  node_q, node_d;
  edge_t          edge_q, edge_d;
  logic           ozero_q, ozero_d;
  logic [CW-1:0]  clr_q, clr_d;
  logic           rv_q, rv_d;
  out_word_t      res_q, res_d;

  // memory ports
  logic            nm_we, nm_re;
  logic [NW-1:0]   nm_waddr, nm_raddr;
  neuron_t         nm_wdata, nm_rdata;
  logic            vm_we, vm_re;
  logic [NW-1:0]   vm_waddr, vm_raddr;
  logic [23:0]     vm_wdata, vm_rdata;
  logic            em_we, em_re;
  logic [EW-1:0]   em_waddr, em_raddr;
  edge_t           em_wdata, em_rdata;
  logic            dm_we, dm_re;
  logic [NW-1:0]   dm_waddr, dm_raddr;
  logic [DW-1:0]   dm_wdata, dm_rdata, dm_dec;
  logic            om_we, om_re;
  logic [NW-1:0]   om_waddr, om_raddr;
  logic [NW-1:0]   om_wdata, om_rdata;

  mac_ctrl_t          mac_ctrl;
  logic signed [23:0] mac_result;

  logic accept;
  int   s_out;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign dm_dec = dm_rdata - DW'(1);
  assign s_out  = int'(ic_q) + int'(j_q);

  sde_ram #(.W($bits(neuron_t)), .D(MAX_NEURONS)) u_neuron_ram (
    .clk_i, .we_i(nm_we), .waddr_i(nm_waddr), .wdata_i(nm_wdata),
    .re_i(nm_re), .raddr_i(nm_raddr), .rdata_o(nm_rdata)
  );

  sde_ram #(.W(24), .D(MAX_NEURONS)) u_value_ram (
    .clk_i, .we_i(vm_we), .waddr_i(vm_waddr), .wdata_i(vm_wdata),
    .re_i(vm_re), .raddr_i(vm_raddr), .rdata_o(vm_rdata)
  );

  sde_ram #(.W($bits(edge_t)), .D(MAX_EDGES)) u_edge_ram (
    .clk_i, .we_i(em_we), .waddr_i(em_waddr), .wdata_i(em_wdata),
    .re_i(em_re), .raddr_i(em_raddr), .rdata_o(em_rdata)
  );

  sde_ram #(.W(DW), .D(MAX_NEURONS)) u_degree_ram (
    .clk_i, .we_i(dm_we), .waddr_i(dm_waddr), .wdata_i(dm_wdata),
    .re_i(dm_re), .raddr_i(dm_raddr), .rdata_o(dm_rdata)
  );

  sde_ram #(.W(NW), .D(MAX_NEURONS)) u_order_ram (
    .clk_i, .we_i(om_we), .waddr_i(om_waddr), .wdata_i(om_wdata),
    .re_i(om_re), .raddr_i(om_raddr), .rdata_o(om_rdata)
  );

  sde_mac #(.ACC_W(ACC_W)) u_mac (
    .clk_i, .rst_ni, .ctrl_i(mac_ctrl), .bias_i(nm_rdata.bias),
    .weight_i(edge_q.weight), .value_i(vm_rdata), .result_o(mac_result)
  );

  // sequencer next state and memory controls
  always_comb begin
    state_d = state_q;
    ov_d    = ov_q;
    ic_d    = ic_q;
    oc_d    = oc_q;
    i_d     = i_q;
    e_d     = e_q;
    head_d  = head_q;
    tail_d  = tail_q;
    pc_d    = pc_q;
    len_d   = len_q;
    j_d     = j_q;
    node_d  = node_q;
    edge_d  = edge_q;
    ozero_d = ozero_q;
    clr_d   = clr_q;
    rv_d    = 1'b0;
    res_d   = res_q;

    nm_we = 1'b0; nm_waddr = '0; nm_wdata = '0; nm_re = 1'b0; nm_raddr = '0;
    vm_we = 1'b0; vm_waddr = '0; vm_wdata = '0; vm_re = 1'b0; vm_raddr = '0;
    em_we = 1'b0; em_waddr = '0; em_wdata = '0; em_re = 1'b0; em_raddr = '0;
    dm_we = 1'b0; dm_waddr = '0; dm_wdata = '0; dm_re = 1'b0; dm_raddr = '0;
    om_we = 1'b0; om_waddr = '0; om_wdata = '0; om_re = 1'b0; om_raddr = '0;
    mac_ctrl = '0;

    case (state_q)
      // wipe neuron and connection tables after reset
      S_CLR: begin
        if (int'(clr_q) < MAX_NEURONS) begin
          nm_we    = 1'b1;
          nm_waddr = NW'(clr_q);
        end
        if (int'(clr_q) < MAX_EDGES) begin
          em_we    = 1'b1;
          em_waddr = EW'(clr_q);
        end
        clr_d = clr_q + CW'(1);
        if (int'(clr_q) == MAXD - 1) begin
          state_d = S_IDLE;
        end
      end

      // command decode
      S_IDLE: begin
        if (accept) begin
          case (in_word_i.op)
            OP_NEURON: begin
              if (int'(in_word_i.neuron_slot) < MAX_NEURONS) begin
                nm_we           = 1'b1;
                nm_waddr        = NW'(in_word_i.neuron_slot);
                nm_wdata.exists = in_word_i.present;
                nm_wdata.bias   = in_word_i.value;
                ov_d            = 1'b0;
              end
            end
            OP_EDGE: begin
              if (int'(in_word_i.edge_slot) < MAX_EDGES) begin
                em_we            = 1'b1;
                em_waddr         = EW'(in_word_i.edge_slot);
                em_wdata.valid   = in_word_i.present;
                em_wdata.enabled = in_word_i.edge_enabled;
                em_wdata.source  = in_word_i.source_neuron;
                em_wdata.target  = in_word_i.target_neuron;
                em_wdata.weight  = in_word_i.value;
                ov_d             = 1'b0;
              end
            end
            OP_PREP: begin
              if (int'(ic_q) + int'(oc_q) > MAX_NEURONS) begin
                ov_d  = 1'b0;
                rv_d  = 1'b1;
                res_d = '{status: ST_MISSING, out_value: '0, out_position: '0, last: 1'b1};
              end else begin
                i_d     = '0;
                state_d = P_A_RD;
              end
            end
            OP_INPUT: begin
              if (in_word_i.neuron_slot < ic_q &&
                  int'(in_word_i.neuron_slot) < MAX_NEURONS) begin
                vm_we    = 1'b1;
                vm_waddr = NW'(in_word_i.neuron_slot);
                vm_wdata = {{8{in_word_i.value[15]}}, in_word_i.value};
              end
              if (in_word_i.input_last) begin
                if (!ov_q) begin
                  rv_d  = 1'b1;
                  res_d = '{status: ST_NOPREP, out_value: '0, out_position: '0, last: 1'b1};
                end else begin
                  i_d     = '0;
                  state_d = E_POP;
                end
              end
            end
            default: ;
          endcase
        end
        // register writes
        if (cfg_we_i) begin
          if (cfg_index_i == REG_INPUT_COUNT) begin
            ic_d = clamp_count(cfg_data_i);
            ov_d = 1'b0;
          end else if (cfg_index_i == REG_OUTPUT_COUNT) begin
            oc_d = clamp_count(cfg_data_i);
            ov_d = 1'b0;
          end
        end
      end

      // input and output slots must exist, degree table cleared on the way
      P_A_RD: begin
        if (i_q == NW1'(MAX_NEURONS)) begin
          e_d     = '0;
          state_d = P_B_RD;
        end else begin
          nm_re    = 1'b1;
          nm_raddr = NW'(i_q);
          dm_we    = 1'b1;
          dm_waddr = NW'(i_q);
          state_d  = P_A_CHK;
        end
      end
      P_A_CHK: begin
        if (int'(i_q) < int'(ic_q) + int'(oc_q) && !nm_rdata.exists) begin
          ov_d    = 1'b0;
          rv_d    = 1'b1;
          res_d   = '{status: ST_MISSING, out_value: '0, out_position: '0, last: 1'b1};
          state_d = S_IDLE;
        end else begin
          i_d     = i_q + NW1'(1);
          state_d = P_A_RD;
        end
      end

      // endpoint check and in-degree count per active edge
      P_B_RD: begin
        if (e_q == EW1'(MAX_EDGES)) begin
          i_d     = '0;
          pc_d    = '0;
          tail_d  = '0;
          state_d = P_C_RD;
        end else begin
          em_re    = 1'b1;
          em_raddr = EW'(e_q);
          state_d  = P_B_E;
        end
      end
      P_B_E: begin
        edge_d = em_rdata;
        if (em_rdata.valid && em_rdata.enabled) begin
          if (int'(em_rdata.source) >= MAX_NEURONS || int'(em_rdata.target) >= MAX_NEURONS) begin
            ov_d    = 1'b0;
            rv_d    = 1'b1;
            res_d   = '{status: ST_MISSING, out_value: '0, out_position: '0, last: 1'b1};
            state_d = S_IDLE;
          end else begin
            nm_re    = 1'b1;
            nm_raddr = NW'(em_rdata.source);
            state_d  = P_B_F;
          end
        end else begin
          e_d     = e_q + EW1'(1);
          state_d = P_B_RD;
        end
      end
      P_B_F: begin
        if (!nm_rdata.exists) begin
          ov_d    = 1'b0;
          rv_d    = 1'b1;
          res_d   = '{status: ST_MISSING, out_value: '0, out_position: '0, last: 1'b1};
          state_d = S_IDLE;
        end else begin
          nm_re    = 1'b1;
          nm_raddr = NW'(edge_q.target);
          state_d  = P_B_T;
        end
      end
      P_B_T: begin
        if (!nm_rdata.exists) begin
          ov_d    = 1'b0;
          rv_d    = 1'b1;
          res_d   = '{status: ST_MISSING, out_value: '0, out_position: '0, last: 1'b1};
          state_d = S_IDLE;
        end else begin
          dm_re    = 1'b1;
          dm_raddr = NW'(edge_q.target);
          state_d  = P_B_INC;
        end
      end
      P_B_INC: begin
        dm_we    = 1'b1;
        dm_waddr = NW'(edge_q.target);
        dm_wdata = dm_rdata + DW'(1);
        e_d      = e_q + EW1'(1);
        state_d  = P_B_RD;
      end

      // seed the queue with existing zero-degree neurons
      P_C_RD: begin
        if (i_q == NW1'(MAX_NEURONS)) begin
          head_d  = '0;
          state_d = P_D_POP;
        end else begin
          nm_re    = 1'b1;
          nm_raddr = NW'(i_q);
          dm_re    = 1'b1;
          dm_raddr = NW'(i_q);
          state_d  = P_C_CHK;
        end
      end
      P_C_CHK: begin
        if (nm_rdata.exists) begin
          pc_d = pc_q + NW1'(1);
          if (dm_rdata == '0) begin
            om_we    = 1'b1;
            om_waddr = NW'(tail_q);
            om_wdata = NW'(i_q);
            tail_d   = tail_q + NW1'(1);
          end
        end
        i_d     = i_q + NW1'(1);
        state_d = P_C_RD;
      end

      // pop a neuron, release its successors; the queue doubles as the order
      P_D_POP: begin
        if (head_q < tail_q) begin
          om_re    = 1'b1;
          om_raddr = NW'(head_q);
          head_d   = head_q + NW1'(1);
          state_d  = P_D_CUR;
        end else begin
          len_d   = head_q;
          rv_d    = 1'b1;
          state_d = S_IDLE;
          if (head_q == pc_q) begin
            ov_d  = 1'b1;
            res_d = '{status: ST_OK, out_value: '0, out_position: '0, last: 1'b1};
          end else begin
            ov_d  = 1'b0;
            res_d = '{status: ST_CYCLE, out_value: '0, out_position: '0, last: 1'b1};
          end
        end
      end
      P_D_CUR: begin
        node_d  = om_rdata;
        e_d     = '0;
        state_d = P_D_RD;
      end
      P_D_RD: begin
        if (e_q == EW1'(MAX_EDGES)) begin
          state_d = P_D_POP;
        end else begin
          em_re    = 1'b1;
          em_raddr = EW'(e_q);
          state_d  = P_D_E;
        end
      end
      P_D_E: begin
        edge_d = em_rdata;
        if (em_rdata.valid && em_rdata.enabled && int'(em_rdata.source) == int'(node_q)) begin
          dm_re    = 1'b1;
          dm_raddr = NW'(em_rdata.target);
          state_d  = P_D_DEC;
        end else begin
          e_d     = e_q + EW1'(1);
          state_d = P_D_RD;
        end
      end
      P_D_DEC: begin
        dm_we    = 1'b1;
        dm_waddr = NW'(edge_q.target);
        dm_wdata = dm_dec;
        if (dm_dec == '0 && int'(tail_q) < MAX_NEURONS) begin
          om_we    = 1'b1;
          om_waddr = NW'(tail_q);
          om_wdata = NW'(edge_q.target);
          tail_d   = tail_q + NW1'(1);
        end
        e_d     = e_q + EW1'(1);
        state_d = P_D_RD;
      end

      // evaluation walk over the order
      E_POP: begin
        if (i_q == len_q) begin
          j_d     = '0;
          state_d = O_RD;
        end else begin
          om_re    = 1'b1;
          om_raddr = NW'(i_q);
          state_d  = E_N;
        end
      end
      E_N: begin
        node_d = om_rdata;
        if (int'(om_rdata) < int'(ic_q)) begin
          i_d     = i_q + NW1'(1);
          state_d = E_POP;
        end else begin
          nm_re    = 1'b1;
          nm_raddr = om_rdata;
          state_d  = E_B;
        end
      end
      E_B: begin
        mac_ctrl.load = 1'b1;
        e_d           = '0;
        state_d       = E_RD;
      end
      E_RD: begin
        if (e_q == EW1'(MAX_EDGES)) begin
          state_d = E_DR;
        end else begin
          em_re    = 1'b1;
          em_raddr = EW'(e_q);
          state_d  = E_E;
        end
      end
      E_E: begin
        edge_d = em_rdata;
        if (em_rdata.valid && em_rdata.enabled &&
            int'(em_rdata.target) == int'(node_q) &&
            int'(em_rdata.source) < MAX_NEURONS) begin
          vm_re    = 1'b1;
          vm_raddr = NW'(em_rdata.source);
          state_d  = E_V;
        end else begin
          e_d     = e_q + EW1'(1);
          state_d = E_RD;
        end
      end
      E_V: begin
        mac_ctrl.add = 1'b1;
        e_d          = e_q + EW1'(1);
        state_d      = E_RD;
      end
      // let the product and accumulate stages drain
      E_DR: begin
        state_d = E_WB;
      end
      E_WB: begin
        vm_we    = 1'b1;
        vm_waddr = node_q;
        vm_wdata = mac_result;
        i_d      = i_q + NW1'(1);
        state_d  = E_POP;
      end

      // emit output neurons one word at a time
      O_RD: begin
        ozero_d = (s_out >= MAX_NEURONS);
        if (s_out < MAX_NEURONS) begin
          vm_re    = 1'b1;
          vm_raddr = NW'(s_out);
        end
        state_d = O_EM;
      end
      O_EM: begin
        rv_d               = 1'b1;
        res_d.status       = ST_OK;
        res_d.out_value    = ozero_q ? '0 : vm_rdata;
        res_d.out_position = j_q[4:0];
        res_d.last         = (j_q + 6'd1 == oc_q);
        j_d                = j_q + 6'd1;
        state_d            = (j_q + 6'd1 == oc_q) ? S_IDLE : O_RD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ov_q    <= 1'b0;
      ic_q    <= 6'd2;
      oc_q    <= 6'd1;
      i_q     <= '0;
      e_q     <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      pc_q    <= '0;
      len_q   <= '0;
      j_q     <= '0;
      clr_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      ic_q    <= ic_d;
      oc_q    <= oc_d;
      i_q     <= i_d;
      e_q     <= e_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      pc_q    <= pc_d;
      len_q   <= len_d;
      j_q     <= j_d;
      clr_q   <= clr_d;
      rv_q    <= rv_d;
    end
  end

  // working payload registers
  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    edge_q  <= edge_d;
    ozero_q <= ozero_d;
    res_q   <= res_d;
  end

  assign result_valid_o = rv_q;
  assign result_o       = res_q;

endmodule

// ===== rtl/sde_checker.sv =====
// port-level checks for the sparse dag network evaluator, bound to the top level
`timescale 1ns / 1ps
module sde_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input sde_pkg::in_word_t  in_word_i,
  input logic               result_valid_o,
  input sde_pkg::out_word_t result_o
);
  import sde_pkg::*;

  // a failure or stale status is always the only word of its item
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status != ST_OK |-> result_o.last)
    else $error("status word without last");

  // status words carry zero value and position
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status != ST_OK |->
      result_o.out_value == '0 && result_o.out_position == '0)
    else $error("status word with payload");

  // more output words pending keeps the block busy
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |=> busy)
    else $error("idle between output words");

  // prepare or final input either answers at once or starts work
  a_trigger: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (in_word_i.op == OP_PREP ||
      (in_word_i.op == OP_INPUT && in_word_i.input_last)) |=> busy || result_valid_o)
    else $error("trigger word dropped");

endmodule

bind sparse_dag_network_evaluator sde_checker u_sde_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .start(start),
  .busy(busy),
  .in_word_i(in_word_i),
  .result_valid_o(result_valid_o),
  .result_o(result_o)
);

// ===== tb/sparse_dag_network_evaluator_test.sv =====
// testbench for the sparse dag network evaluator: directed table, random networks, predictor
`timescale 1ns / 1ps
module sparse_dag_network_evaluator_test;
  import sde_pkg::*;

  localparam int NN = 64;
  localparam int NE = 256;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_word_i = '0;
  logic result_valid_o;
  out_word_t result_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [5:0] cfg_data_i = '0;

  sparse_dag_network_evaluator u_top (
    .clk_i, .rst_ni, .start, .busy, .in_word_i, .result_valid_o, .result_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  int unsigned n_in, n_out;
  bit net_exists[NN];
  int net_bias[NN];
  longint net_val[NN];
  bit e_valid[NE], e_en[NE];
  int e_src[NE], e_dst[NE], e_wt[NE];
  int order_q[$];
  bit order_ok;

  out_word_t expected_words[$];
  bit failed = 0;
  int sent = 0;

  // directed rows with typed-in result, where known
  typedef struct {
    in_word_t w;
    bit has_exp;
    out_word_t exp;
  } row_t;

  function automatic int kahn_sort();
    int deg[NN];
    int rq[$];
    int cnt, cur;
    cnt = 0;
    order_q.delete();
    for (int i = 0; i < n_in + n_out; i++)
      if (i >= NN || !net_exists[i]) return ST_MISSING;
    for (int e = 0; e < NE; e++)
      if (e_valid[e] && e_en[e] && (!net_exists[e_src[e]] || !net_exists[e_dst[e]]))
        return ST_MISSING;
    for (int i = 0; i < NN; i++) deg[i] = 0;
    for (int e = 0; e < NE; e++)
      if (e_valid[e] && e_en[e]) deg[e_dst[e]]++;
    for (int i = 0; i < NN; i++)
      if (net_exists[i]) begin
        cnt++;
        if (deg[i] == 0) rq = {rq, i};
      end
    while (rq.size() > 0) begin
      cur = rq.pop_front();
      order_q = {order_q, cur};
      for (int e = 0; e < NE; e++)
        if (e_valid[e] && e_en[e] && e_src[e] == cur) begin
          deg[e_dst[e]]--;
          if (deg[e_dst[e]] == 0) rq = {rq, e_dst[e]};
        end
    end
    return (order_q.size() != cnt) ? ST_CYCLE : ST_OK;
  endfunction

  function automatic longint relu_round(longint acc);
    longint t, r;
    t = acc + 2048;
    r = t >>> 12;
    if (r > 8388607) r = 8388607;
    if (r < 0) r = 0;
    return r;
  endfunction

  // append one expected result word
  function automatic void queue_word(out_word_t o);
    expected_words = {expected_words, o};
  endfunction

  // predict results of one accepted word
  function automatic void predict_word(in_word_t w);
    out_word_t o;
    longint acc;
    int n;
    case (w.op)
      OP_NEURON: begin
        net_exists[w.neuron_slot] = w.present;
        net_bias[w.neuron_slot] = w.value;
        order_ok = 0;
      end
      OP_EDGE: begin
        e_valid[w.edge_slot] = w.present;
        e_en[w.edge_slot] = w.edge_enabled;
        e_src[w.edge_slot] = w.source_neuron;
        e_dst[w.edge_slot] = w.target_neuron;
        e_wt[w.edge_slot] = w.value;
        order_ok = 0;
      end
      OP_PREP: begin
        o = '0;
        o.status = 2'(kahn_sort());
        o.last = 1'b1;
        order_ok = (o.status == ST_OK);
        queue_word(o);
      end
      default: begin
        if (w.neuron_slot < n_in) net_val[w.neuron_slot] = w.value;
        if (w.input_last) begin
          if (!order_ok) begin
            o = '0;
            o.status = ST_NOPREP;
            o.last = 1'b1;
            queue_word(o);
          end else begin
            foreach (order_q[k]) begin
              n = order_q[k];
              if (n >= n_in) begin
                acc = longint'(net_bias[n]) * 4096;
                for (int e = 0; e < NE; e++)
                  if (e_valid[e] && e_en[e] && e_dst[e] == n)
                    acc += longint'(e_wt[e]) * net_val[e_src[e]];
                net_val[n] = relu_round(acc);
              end
            end
            for (int j = 0; j < n_out; j++) begin
              o = '0;
              o.status = ST_OK;
              o.out_value = 24'(net_val[n_in + j]);
              o.out_position = 5'(j);
              o.last = (j + 1 == n_out);
              queue_word(o);
            end
          end
        end
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word exp none act %h", $time, result_o);
        failed = 1;
      end else begin
        if (result_o !== expected_words[0]) begin
          $display("%0t: mismatch exp st=%0d v=%0d p=%0d l=%0d act st=%0d v=%0d p=%0d l=%0d",
                   $time, expected_words[0].status, expected_words[0].out_value,
                   expected_words[0].out_position, expected_words[0].last,
                   result_o.status, result_o.out_value, result_o.out_position,
                   result_o.last);
          failed = 1;
        end
        void'(expected_words.pop_front());
      end
    end
  end

  // start stays high across back-to-back words and drops only before a gap
  task automatic send_word(in_word_t w);
    int gap;
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (busy);
    sent++;
    predict_word(w);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_words.size() > 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] d);
    int unsigned v;
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    v = (d == 6'd0) ? 1 : (d > 6'd32) ? 32 : int'(d);
    if (idx == REG_INPUT_COUNT) begin
      n_in = v;
      order_ok = 0;
    end else if (idx == REG_OUTPUT_COUNT) begin
      n_out = v;
      order_ok = 0;
    end
  endtask

  function automatic in_word_t mk(logic [1:0] op, int ns, int es, bit p, int s, int t,
                                   int v, bit en, bit l);
    in_word_t w;
    w.op = op; w.neuron_slot = 6'(ns); w.edge_slot = 8'(es); w.present = p;
    w.source_neuron = 6'(s); w.target_neuron = 6'(t); w.value = 16'(v);
    w.edge_enabled = en; w.input_last = l;
    return w;
  endfunction

  function automatic out_word_t st_word(logic [1:0] st);
    out_word_t o;
    o = '0; o.status = st; o.last = 1'b1;
    return o;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    logic [63:0] r;
    r = {$urandom, $urandom};
    w = r[$bits(in_word_t)-1:0];
    return w;
  endfunction

  // random layered network over slots 0..nn-1, then prepare and one to three vectors
  task automatic random_net();
    int ni, no, nn, ne, s, t;
    ni = $urandom_range(1, 4);
    no = $urandom_range(1, 4);
    if ($urandom_range(0, 9) == 0) begin ni = $urandom_range(1, 32); no = 32; end
    nn = ni + no + $urandom_range(0, 4);
    if (nn > NN) nn = NN;
    drain();
    write_reg(REG_INPUT_COUNT, 6'(ni));
    write_reg(REG_OUTPUT_COUNT, 6'(no));
    for (int i = 0; i < NN; i++)
      if (i < nn || net_exists[i])
        send_word(mk(OP_NEURON, i, 0, i < nn, 0, 0, $urandom, 0, 0));
    ne = $urandom_range(2, 12);
    for (int e = 0; e < ne; e++) begin
      s = $urandom_range(0, nn - 1);
      t = $urandom_range(ni, nn - 1);
      // mostly forward edges; occasional back edge makes a cycle
      if (s >= t && $urandom_range(0, 9) != 0) s = $urandom_range(0, ni - 1);
      send_word(mk(OP_EDGE, 0, $urandom_range(0, 255), $urandom_range(0, 7) != 0, s, t,
                   $urandom, $urandom_range(0, 7) != 0, 1'($urandom)));
    end
    if ($urandom_range(0, 5) == 0) send_word(rand_word());
    send_word(mk(OP_PREP, 0, 0, 0, 0, 0, 0, 0, 0));
    repeat ($urandom_range(1, 3)) begin
      for (int i = 0; i < ni; i++)
        send_word(mk(OP_INPUT, i, $urandom, 1'($urandom), $urandom, $urandom, $urandom,
                     1'($urandom), i == ni - 1));
      drain();
    end
  endtask

  row_t rows[$];

  // append one directed row
  function automatic void add_row(in_word_t w, bit has_exp, out_word_t exp);
    row_t r;
    r.w = w;
    r.has_exp = has_exp;
    r.exp = exp;
    rows = {rows, r};
  endfunction

  initial begin
    n_in = 2; n_out = 1; order_ok = 0;
    for (int e = 0; e < NE; e++) e_valid[e] = 0;
    for (int i = 0; i < NN; i++) begin
      net_exists[i] = 0; net_bias[i] = 0; net_val[i] = 0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: stale order, missing endpoint, cycle, extremes
    add_row(mk(OP_INPUT, 5, 0, 0, 0, 0, 0, 0, 1), 1, st_word(ST_NOPREP));
    add_row(mk(OP_PREP, 0, 0, 0, 0, 0, 0, 0, 0), 1, st_word(ST_MISSING));
    add_row(mk(OP_NEURON, 0, 0, 1, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_NEURON, 1, 0, 1, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_NEURON, 2, 0, 1, 0, 0, 32767, 0, 0), 0, '0);
    add_row(mk(OP_NEURON, 3, 0, 1, 0, 0, -32768, 0, 0), 0, '0);
    add_row(mk(OP_EDGE, 0, 255, 1, 0, 2, 32767, 1, 0), 0, '0);
    add_row(mk(OP_EDGE, 0, 0, 1, 1, 2, -32768, 1, 0), 0, '0);
    add_row(mk(OP_EDGE, 0, 7, 1, 63, 2, 100, 1, 0), 0, '0);
    add_row(mk(OP_PREP, 0, 0, 0, 0, 0, 0, 0, 0), 1, st_word(ST_MISSING));
    add_row(mk(OP_EDGE, 0, 7, 1, 63, 2, 100, 0, 0), 0, '0);
    add_row(mk(OP_EDGE, 0, 8, 1, 3, 2, 5, 1, 0), 0, '0);
    add_row(mk(OP_EDGE, 0, 9, 1, 2, 3, 5, 1, 0), 0, '0);
    add_row(mk(OP_PREP, 0, 0, 0, 0, 0, 0, 0, 0), 1, st_word(ST_CYCLE));
    add_row(mk(OP_EDGE, 0, 9, 0, 2, 3, 5, 1, 0), 0, '0);
    add_row(mk(OP_PREP, 0, 0, 0, 0, 0, 0, 0, 0), 1, st_word(ST_OK));
    add_row(mk(OP_INPUT, 0, 0, 0, 0, 0, 32767, 0, 0), 0, '0);
    add_row(mk(OP_INPUT, 1, 0, 0, 0, 0, -32768, 0, 1), 0, '0);
    add_row(mk(OP_INPUT, 1, 0, 0, 0, 0, 32767, 0, 0), 0, '0);
    add_row(mk(OP_INPUT, 63, 0, 0, 0, 0, -1, 0, 1), 0, '0);
    add_row(mk(OP_INPUT, 0, 0, 0, 0, 0, -32768, 0, 1), 0, '0);
    foreach (rows[r]) begin
      if (rows[r].has_exp) begin
        // typed-in result must agree with the predictor too
        send_word(rows[r].w);
        if (expected_words[$] !== rows[r].exp) begin
          $display("%0t: table row %0d exp %h act %h", $time, r, rows[r].exp,
                   expected_words[$]);
          failed = 1;
        end
      end else send_word(rows[r].w);
    end

    // register extremes, with clamping
    drain();
    write_reg(REG_INPUT_COUNT, 6'd0);
    write_reg(REG_OUTPUT_COUNT, 6'd63);
    send_word(mk(OP_INPUT, 0, 0, 0, 0, 0, 1, 0, 1));
    send_word(mk(OP_PREP, 0, 0, 0, 0, 0, 0, 0, 0));

    // random networks until about 100 items
    while (sent < 100) begin
      random_net();
    end
    drain();
    if (failed || expected_words.size() != 0)
      $display("Verification failed");
    else
      $display("Verification passed");
    $finish;
  end

  initial begin
    #400ms;
    $display("Verification failed");
    $finish;
  end
endmodule
